[sv/lusa_pkg.sv]
package lusa_pkg;

  localparam int SLOT_BITS      = 5;
  localparam int DEF_SLOTS      = 17;
  localparam int DEF_COUNT_BITS = 8;

  localparam logic ACT_ACQUIRE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // update order broadcast to every cell, applied at the next edge
  typedef struct packed {
    logic                 inc;
    logic                 dec;
    logic [SLOT_BITS-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam logic [SLOT_BITS-1:0] SLOT_0  = 5'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_1  = 5'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_2  = 5'd2;
  localparam logic [SLOT_BITS-1:0] SLOT_3  = 5'd3;
  localparam logic [SLOT_BITS-1:0] SLOT_4  = 5'd4;
  localparam logic [SLOT_BITS-1:0] SLOT_5  = 5'd5;
  localparam logic [SLOT_BITS-1:0] SLOT_6  = 5'd6;
  localparam logic [SLOT_BITS-1:0] SLOT_7  = 5'd7;
  localparam logic [SLOT_BITS-1:0] SLOT_8  = 5'd8;
  localparam logic [SLOT_BITS-1:0] SLOT_9  = 5'd9;
  localparam logic [SLOT_BITS-1:0] SLOT_10 = 5'd10;
  localparam logic [SLOT_BITS-1:0] SLOT_11 = 5'd11;
  localparam logic [SLOT_BITS-1:0] SLOT_12 = 5'd12;
  localparam logic [SLOT_BITS-1:0] SLOT_13 = 5'd13;
  localparam logic [SLOT_BITS-1:0] SLOT_14 = 5'd14;
  localparam logic [SLOT_BITS-1:0] SLOT_15 = 5'd15;
  localparam logic [SLOT_BITS-1:0] SLOT_16 = 5'd16;

  // color rom, slots above the table are black
  function automatic color_t slot_color(input logic [SLOT_BITS-1:0] idx);
    color_t c;
    unique case (idx)
      SLOT_0:  c = '{8'd0,   8'd0,   8'd64};
      SLOT_1:  c = '{8'd64,  8'd0,   8'd0};
      SLOT_2:  c = '{8'd0,   8'd64,  8'd0};
      SLOT_3:  c = '{8'd32,  8'd0,   8'd32};
      SLOT_4:  c = '{8'd12,  8'd23,  8'd29};
      SLOT_5:  c = '{8'd0,   8'd86,  8'd0};
      SLOT_6:  c = '{8'd105, 8'd0,   8'd98};
      SLOT_7:  c = '{8'd0,   8'd114, 8'd0};
      SLOT_8:  c = '{8'd97,  8'd0,   8'd116};
      SLOT_9:  c = '{8'd0,   8'd105, 8'd0};
      SLOT_10: c = '{8'd111, 8'd0,   8'd110};
      SLOT_11: c = '{8'd0,   8'd32,  8'd0};
      SLOT_12: c = '{8'd84,  8'd0,   8'd105};
      SLOT_13: c = '{8'd0,   8'd109, 8'd0};
      SLOT_14: c = '{8'd101, 8'd0,   8'd111};
      SLOT_15: c = '{8'd0,   8'd117, 8'd0};
      SLOT_16: c = '{8'd116, 8'd0,   8'd0};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

[sv/lusa_cell.sv]
module lusa_cell #(
  parameter int COUNT_BITS = lusa_pkg::DEF_COUNT_BITS,
  parameter int CELL_ID    = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lusa_pkg::cmd_t                 cmd,
  input  logic                           tok_in_vld,
  input  logic [lusa_pkg::SLOT_BITS-1:0] tok_in_idx,
  input  logic [COUNT_BITS-1:0]          tok_in_cnt,
  output logic                           tok_out_vld,
  output logic [lusa_pkg::SLOT_BITS-1:0] tok_out_idx,
  output logic [COUNT_BITS-1:0]          tok_out_cnt
);

  localparam logic [lusa_pkg::SLOT_BITS-1:0] ID = lusa_pkg::SLOT_BITS'(CELL_ID);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      tok_out_vld <= 1'b0;
    end else begin
      if (cmd.slot == ID) begin
        if (cmd.inc && count != CNT_MAX) begin
          count <= count + CNT_ONE;
        end else if (cmd.dec && count != '0) begin
          count <= count - CNT_ONE;
        end
      end
      tok_out_vld <= tok_in_vld;
    end
  end

  // strictly smaller wins, so ties keep the lower slot
  always_ff @(posedge clk) begin
    if (count < tok_in_cnt) begin
      tok_out_idx <= ID;
      tok_out_cnt <= count;
    end else begin
      tok_out_idx <= tok_in_idx;
      tok_out_cnt <= tok_in_cnt;
    end
  end

endmodule

[sv/least_used_slot_allocator.sv]
// Reference-count slot allocator. Each slot keeps a saturating use count in a
// cell of a chain; an acquire item sends a minimum-search token down the chain,
// one cell per cycle, and grants the lowest slot with the smallest count,
// returning its index and fixed color. An acquire's token travels the chain,
// the winner is captured, and the grant waits for the output register to
// free; the next item is taken only after the grant. A release item lowers
// the named count by one (never below zero) and gives no result; release of
// a slot number of SLOTS or more is ignored. Counts clear at reset.
module least_used_slot_allocator #(
  parameter int SLOTS      = lusa_pkg::DEF_SLOTS,
  parameter int COUNT_BITS = lusa_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [lusa_pkg::SLOT_BITS-1:0] release_slot,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lusa_pkg::SLOT_BITS-1:0] slot_index,
  output logic [7:0]                     red,
  output logic [7:0]                     green,
  output logic [7:0]                     blue
);

  typedef enum logic [1:0] {IDLE, SCAN, GRANT} state_t;

  state_t                           state;
  lusa_pkg::cmd_t                   cmd;
  logic                             inject;
  logic [lusa_pkg::SLOT_BITS-1:0]   best_idx;
  lusa_pkg::color_t                 color;

  logic                             tv [0:SLOTS];
  logic [lusa_pkg::SLOT_BITS-1:0]   ti [0:SLOTS];
  logic [COUNT_BITS-1:0]            tc [0:SLOTS];

  logic in_acc;
  logic out_free;

  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign color    = lusa_pkg::slot_color(best_idx);

  // token starts as slot 0 at the largest count
  assign tv[0] = inject;
  assign ti[0] = '0;
  assign tc[0] = {COUNT_BITS{1'b1}};

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    lusa_cell #(
      .COUNT_BITS(COUNT_BITS),
      .CELL_ID   (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .tok_in_vld (tv[k]),
      .tok_in_idx (ti[k]),
      .tok_in_cnt (tc[k]),
      .tok_out_vld(tv[k+1]),
      .tok_out_idx(ti[k+1]),
      .tok_out_cnt(tc[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      inject    <= 1'b0;
      cmd       <= '0;
      out_valid <= 1'b0;
    end else begin
      inject <= 1'b0;
      cmd    <= '0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            if (action == lusa_pkg::ACT_RELEASE) begin
              cmd.dec  <= 1'b1;
              cmd.slot <= release_slot;
            end else begin
              inject <= 1'b1;
              state  <= SCAN;
            end
          end
        end
        SCAN: begin
          if (tv[SLOTS]) begin
            best_idx <= ti[SLOTS];
            state    <= GRANT;
          end
        end
        GRANT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            slot_index <= best_idx;
            red        <= color.red;
            green      <= color.green;
            blue       <= color.blue;
            cmd.inc    <= 1'b1;
            cmd.slot   <= best_idx;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[tb/least_used_slot_allocator_tb.sv]
module least_used_slot_allocator_tb;

  localparam int SLOTS          = lusa_pkg::DEF_SLOTS;
  localparam int COUNT_BITS     = lusa_pkg::DEF_COUNT_BITS;
  localparam int SLOT_BITS      = lusa_pkg::SLOT_BITS;
  localparam int GRANT_LATENCY  = SLOTS + 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 675;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP     = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE     = COUNT_BITS'(1);
  localparam logic [SLOT_BITS-1:0]  SLOT_PAST_END = 5'd17;
  localparam logic [SLOT_BITS-1:0]  SLOT_TOP      = 5'd31;

  // fixed color of every slot, red/green/blue
  localparam logic [23:0] SLOT_RGB [0:SLOTS-1] = '{
    {8'd0,   8'd0,   8'd64},  {8'd64,  8'd0,   8'd0},   {8'd0,   8'd64,  8'd0},
    {8'd32,  8'd0,   8'd32},  {8'd12,  8'd23,  8'd29},  {8'd0,   8'd86,  8'd0},
    {8'd105, 8'd0,   8'd98},  {8'd0,   8'd114, 8'd0},   {8'd97,  8'd0,   8'd116},
    {8'd0,   8'd105, 8'd0},   {8'd111, 8'd0,   8'd110}, {8'd0,   8'd32,  8'd0},
    {8'd84,  8'd0,   8'd105}, {8'd0,   8'd109, 8'd0},   {8'd101, 8'd0,   8'd111},
    {8'd0,   8'd117, 8'd0},   {8'd116, 8'd0,   8'd0}
  };

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } grant_t;

  // directed row: known marks a grant typed in by hand
  typedef struct packed {
    logic                 act;
    logic [SLOT_BITS-1:0] slot;
    logic                 known;
    logic [SLOT_BITS-1:0] grant;
  } step_t;

  localparam int DIRECTED_ROWS = 25;
  localparam step_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_ACQUIRE, SLOT_TOP,          1'b1, lusa_pkg::SLOT_1},
    {lusa_pkg::ACT_RELEASE, SLOT_TOP,          1'b0, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_RELEASE, SLOT_PAST_END,     1'b0, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_RELEASE, lusa_pkg::SLOT_16, 1'b0, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_RELEASE, lusa_pkg::SLOT_0,  1'b0, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_2},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_3},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_4},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_5},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_6},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_7},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_8},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_9},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_10},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_11},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_12},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_13},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_14},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_15},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_16},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_RELEASE, lusa_pkg::SLOT_16, 1'b0, lusa_pkg::SLOT_0},
    {lusa_pkg::ACT_ACQUIRE, lusa_pkg::SLOT_0,  1'b1, lusa_pkg::SLOT_16}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [SLOT_BITS-1:0] release_slot;
  logic                 out_valid;
  logic                 out_stall;
  logic [SLOT_BITS-1:0] slot_index;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;

  logic [COUNT_BITS-1:0] use_count [0:SLOTS-1];
  grant_t                pending_grants [$];

  int  errors;
  int  acquires;
  int  releases;
  int  stray_releases;
  int  grants_checked;
  int  idle_cycles;
  bit  calm;
  bit  hold_off_req;

  least_used_slot_allocator #(
    .SLOTS     (SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .release_slot(release_slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot_index  (slot_index),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // lowest slot among the smallest counts wins, count saturates
  function automatic grant_t grant_least_used();
    grant_t g;
    int     best;
    best = 0;
    for (int k = 1; k < SLOTS; k++)
      if (use_count[k] < use_count[best]) best = k;
    if (use_count[best] != COUNT_TOP) use_count[best] = use_count[best] + COUNT_ONE;
    g.slot = best[SLOT_BITS-1:0];
    {g.red, g.green, g.blue} = SLOT_RGB[best];
    return g;
  endfunction

  function automatic void apply_release(input logic [SLOT_BITS-1:0] slot);
    if (slot < SLOTS && use_count[slot] != '0) use_count[slot] = use_count[slot] - COUNT_ONE;
  endfunction

  // offers one item and returns at the edge where it is taken
  task automatic offer_item(input logic act, input logic [SLOT_BITS-1:0] slot,
                            input bit known, input logic [SLOT_BITS-1:0] grant);
    grant_t g;
    if (!calm)
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid     <= 1'b1;
    action       <= act;
    release_slot <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == lusa_pkg::ACT_ACQUIRE) begin
      acquires++;
      g = grant_least_used();
      if (known) begin
        g.slot = grant;
        {g.red, g.green, g.blue} = SLOT_RGB[grant];
      end
      pending_grants.push_back(g);
    end else begin
      releases++;
      if (slot >= SLOTS) stray_releases++;
      apply_release(slot);
    end
  endtask

  task automatic drain_grants();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (GRANT_LATENCY) @(posedge clk);
  endtask

  task automatic offer_random(input bit acquire_only);
    logic                 act;
    logic [SLOT_BITS-1:0] slot;
    act = (acquire_only || $urandom_range(99) < 55) ? lusa_pkg::ACT_ACQUIRE
                                                    : lusa_pkg::ACT_RELEASE;
    if (act == lusa_pkg::ACT_ACQUIRE || $urandom_range(9) == 0)
      slot = SLOT_BITS'($urandom_range(31));
    else
      slot = SLOT_BITS'($urandom_range(SLOTS - 1));
    offer_item(act, slot, 1'b0, lusa_pkg::SLOT_0);
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: grant slot %0d with nothing expected", $time, slot_index);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        grants_checked++;
        if (slot_index !== want.slot) begin
          $display("%0t: slot_index expected %0d got %0d", $time, want.slot, slot_index);
          errors++;
        end
        if (red !== want.red) begin
          $display("%0t: red expected %0d got %0d", $time, want.red, red);
          errors++;
        end
        if (green !== want.green) begin
          $display("%0t: green expected %0d got %0d", $time, want.green, green);
          errors++;
        end
        if (blue !== want.blue) begin
          $display("%0t: blue expected %0d got %0d", $time, want.blue, blue);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("least_used_slot_allocator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_valid       = 1'b0;
    action         = lusa_pkg::ACT_ACQUIRE;
    release_slot   = lusa_pkg::SLOT_0;
    errors         = 0;
    acquires       = 0;
    releases       = 0;
    stray_releases = 0;
    grants_checked = 0;
    idle_cycles    = 0;
    calm           = 1'b0;
    hold_off_req   = 1'b0;
    for (int k = 0; k < SLOTS; k++) use_count[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++)
      offer_item(DIRECTED[r].act, DIRECTED[r].slot, DIRECTED[r].known, DIRECTED[r].grant);
    // sender waits for every grant before the random part
    drain_grants();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) hold_off_req = 1'b1;
      calm = (i >= 400 && i < 550);
      // keep acquiring through the hold-off so the block backs up
      offer_random(i >= 150 && i < 190);
    end
    calm = 1'b0;
    drain_grants();

    $display("run: %0d acquires, %0d releases (%0d out of range), %0d grants checked",
             acquires, releases, stray_releases, grants_checked);
    $display("run: directed corners, empty and stray releases, long hold-off, no-idle stretch");
    if (errors == 0)
      $display("least_used_slot_allocator verification clean");
    else
      $display("least_used_slot_allocator verification failed");
    $finish;
  end

endmodule

[files.f]
sv/lusa_pkg.sv
sv/lusa_cell.sv
sv/least_used_slot_allocator.sv
tb/least_used_slot_allocator_tb.sv
